@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hw/rtl/tas_pkg.sv @@
// types and constants of the texture address sampler
`default_nettype none

package tas_pkg;

    localparam int MAX_DIM     = 256;
    localparam int TEXEL_DEPTH = 65536;

    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int MC_W    = FRAC_W + 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int IDX_W   = 2 * DIM_W;
    localparam int ADDR_W  = $clog2(TEXEL_DEPTH);
    localparam int RGB_W   = 24;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [COORD_W-1:0] Q_ZERO = '0;
    localparam logic [COORD_W-1:0] Q_ONE  = COORD_W'(1) << FRAC_W;
    localparam logic [COORD_W-1:0] Q_TWO  = COORD_W'(2) << FRAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_COLOR = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET    = DIM_W'(MAX_DIM);
    localparam logic [RGB_W-1:0] BORDER_RESET = 24'hFFC0CB;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MODE_BORDER = 2'd0,
        MODE_CLAMP  = 2'd1,
        MODE_MIRROR = 2'd2,
        MODE_WRAP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_IDX,
        ST_READ,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic capture;
        logic write;
        logic map_en;
        logic mul_en;
        logic idx_en;
        logic rd_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/tas_ctrl.sv @@
// sequencer of the texture address sampler
`default_nettype none

module tas_ctrl import tas_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire logic i_op,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_slot_free = !i_sts.out_full || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_op'(i_op) == OP_SAMPLE)) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_IDX;
            ST_IDX:  n_state = ST_READ;
            ST_READ: n_state = ST_RESULT;
            ST_RESULT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.capture = w_accept && (t_op'(i_op) == OP_SAMPLE);
                o_cmd.write   = w_accept && (t_op'(i_op) == OP_WRITE);
            end
            ST_MAP:    o_cmd.map_en   = 1'b1;
            ST_MUL:    o_cmd.mul_en   = 1'b1;
            ST_IDX:    o_cmd.idx_en   = 1'b1;
            ST_READ:   o_cmd.rd_en    = 1'b1;
            ST_RESULT: o_cmd.out_load = w_slot_free;
            default:   o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tas_dpath.sv @@
// coordinate mapping, index arithmetic, texel store and result register
`default_nettype none

module tas_dpath import tas_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_sts                           o_sts,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_wdata,
    input  wire logic [15:0]               i_texel_addr,
    input  wire logic [RGB_W-1:0]          i_texel_rgb,
    input  wire logic signed [COORD_W-1:0] i_coord_u,
    input  wire logic signed [COORD_W-1:0] i_coord_v,
    input  wire logic [1:0]                i_addr_mode,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output logic [RGB_W-1:0]               o_sample_rgb,
    output logic                           o_border_hit
);

    // maps one coordinate into [0, one]; in border mode its low bits pass through unmapped
    function automatic logic [MC_W-1:0] map_coord(input logic [COORD_W-1:0] c,
                                                  input t_mode m);
        logic                neg;
        logic                above;
        logic [COORD_W-1:0]  a;
        logic [COORD_W-1:0]  t;
        neg   = c[COORD_W-1];
        above = !neg && (c > Q_ONE);
        a     = neg ? (Q_ZERO - c) : c;
        t     = c;
        case (m)
            MODE_BORDER: t = c;
            MODE_CLAMP: begin
                if (neg) begin
                    t = Q_ZERO;
                end else if (above) begin
                    t = Q_ONE;
                end
            end
            MODE_MIRROR: begin
                t = a;
                if (t > Q_TWO) begin
                    t = ((t - COORD_W'(1)) & (Q_TWO - COORD_W'(1))) + COORD_W'(1);
                end
                if (t > Q_ONE) begin
                    t = Q_TWO - t;
                end
            end
            default: begin
                if (above) begin
                    t = ((c - COORD_W'(1)) & (Q_ONE - COORD_W'(1))) + COORD_W'(1);
                end else if (neg) begin
                    t = c & (Q_ONE - COORD_W'(1));
                end
            end
        endcase
        return t[MC_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            return DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return d;
    endfunction

    function automatic logic out_of_unit(input logic [COORD_W-1:0] c);
        return c[COORD_W-1] || (c > Q_ONE);
    endfunction

    logic [DIM_W-1:0]    r_tex_width;
    logic [DIM_W-1:0]    r_tex_height;
    logic [RGB_W-1:0]    r_border_color;

    logic [COORD_W-1:0]  r_u;
    logic [COORD_W-1:0]  r_v;
    t_mode               r_mode;
    logic [MC_W-1:0]     r_mu;
    logic [MC_W-1:0]     r_mv;
    logic                r_border;
    logic [DIM_W-1:0]    r_ui;
    logic [DIM_W-1:0]    r_vi;
    logic [ADDR_W-1:0]   r_idx;
    logic [RGB_W-1:0]    r_rdata;
    logic [RGB_W-1:0]    r_mem [TEXEL_DEPTH];
    logic                r_out_valid;
    logic [RGB_W-1:0]    r_out_rgb;
    logic                r_out_border;

    logic [DIM_W-1:0]        w_w;
    logic [DIM_W-1:0]        w_h;
    logic [DIM_W-1:0]        w_wm1;
    logic [DIM_W-1:0]        w_hm1;
    logic [MC_W+DIM_W-1:0]   w_prod_u;
    logic [MC_W+DIM_W-1:0]   w_prod_v;
    logic [IDX_W-1:0]        w_sum;

    assign w_w      = sat_dim(r_tex_width);
    assign w_h      = sat_dim(r_tex_height);
    assign w_wm1    = w_w - DIM_W'(1);
    assign w_hm1    = w_h - DIM_W'(1);
    assign w_prod_u = (MC_W+DIM_W)'(r_mu) * (MC_W+DIM_W)'(w_wm1);
    assign w_prod_v = (MC_W+DIM_W)'(r_mv) * (MC_W+DIM_W)'(w_hm1);
    assign w_sum    = (IDX_W'(r_vi) * IDX_W'(w_w)) + IDX_W'(r_ui);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width    <= DIM_RESET;
            r_tex_height   <= DIM_RESET;
            r_border_color <= BORDER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEX_WIDTH:    r_tex_width    <= i_cfg_wdata[DIM_W-1:0];
                CFG_TEX_HEIGHT:   r_tex_height   <= i_cfg_wdata[DIM_W-1:0];
                CFG_BORDER_COLOR: r_border_color <= i_cfg_wdata[RGB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_u    <= i_coord_u;
            r_v    <= i_coord_v;
            r_mode <= t_mode'(i_addr_mode);
        end
        if (i_cmd.map_en) begin
            r_mu     <= map_coord(r_u, r_mode);
            r_mv     <= map_coord(r_v, r_mode);
            r_border <= (r_mode == MODE_BORDER) && (out_of_unit(r_u) || out_of_unit(r_v));
        end
        if (i_cmd.mul_en) begin
            r_ui <= w_prod_u[FRAC_W +: DIM_W];
            r_vi <= w_prod_v[FRAC_W +: DIM_W];
        end
        if (i_cmd.idx_en) begin
            if (w_sum >= IDX_W'(TEXEL_DEPTH)) begin
                r_idx <= ADDR_W'(TEXEL_DEPTH - 1);
            end else begin
                r_idx <= w_sum[ADDR_W-1:0];
            end
        end
    end

    // texel store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_texel_addr) < TEXEL_DEPTH)) begin
            r_mem[i_texel_addr[ADDR_W-1:0]] <= i_texel_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rgb    <= r_border ? r_border_color : r_rdata;
            r_out_border <= r_border;
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_sample_rgb   = r_out_rgb;
    assign o_border_hit   = r_out_border;

endmodule

`default_nettype wire

@@ hw/rtl/texture_address_sampler.sv @@
// top level of the point-sampling texture address sampler
//
// input channel: i_in_valid / o_in_stall carry one transaction per accepted item
// a write transaction (op 0) stores i_texel_rgb at i_texel_addr in the texel store
// and is taken whenever the sequencer is idle, so writes stream one per clock while idle
// a sample transaction (op 1) maps u and v by i_addr_mode (border, clamp, mirror,
// wrap), forms the texel index and reads the store
// sample steps: after acceptance the sequencer runs the map, multiply, index,
// memory read and result steps in that order, returns to idle as the result is
// loaded and only then takes the next item, so one sample finishes before the next
// output channel: o_out_valid / i_out_stall; the result sits in an output register
// and a stalled result holds; the sequencer waits in its last step until the
// register is free or being emptied
// reset: synchronous, active low; sets width and height to 256 and the border
// color to its default; texel store contents are undefined until written
// configuration: i_cfg_we writes register i_cfg_idx (0 width, 1 height,
// 2 border color); the user must use it only while no sample is in flight, as the block does not enforce this
`default_nettype none

`include "assert_macros.svh"

module texture_address_sampler import tas_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // configuration write port
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [CFG_W-1:0]          i_cfg_wdata,
    // input channel
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic                      i_op,
    input  wire logic [15:0]               i_texel_addr,
    input  wire logic [RGB_W-1:0]          i_texel_rgb,
    input  wire logic signed [COORD_W-1:0] i_coord_u,
    input  wire logic signed [COORD_W-1:0] i_coord_v,
    input  wire logic [1:0]                i_addr_mode,
    // output channel
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [RGB_W-1:0]               o_sample_rgb,
    output logic                           o_border_hit
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: one sample in flight, writes pass straight through in idle
    tas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: config registers, coordinate mapping, index math, store, result
    tas_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_texel_addr (i_texel_addr),
        .i_texel_rgb  (i_texel_rgb),
        .i_coord_u    (i_coord_u),
        .i_coord_v    (i_coord_v),
        .i_addr_mode  (i_addr_mode),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_rgb (o_sample_rgb),
        .o_border_hit (o_border_hit)
    );

    // an accepted sample closes the input until its result is loaded
    `ASSERT_CLK(a_sample_blocks_input,
        (i_in_valid && !o_in_stall && i_op) |=> o_in_stall, "input open after sample accept")

    // a result only appears after the sequencer loaded it
    `ASSERT_CLK(a_result_from_load,
        $rose(o_out_valid) |-> $past(w_cmd.out_load), "result without load")

    // a load never overwrites a result that is still stalled
    `ASSERT_NEVER(a_no_overwrite,
        w_cmd.out_load && o_out_valid && i_out_stall, "stalled result overwritten")

    // the store is never written while a sample is in flight
    `ASSERT_NEVER(a_write_only_idle, w_cmd.write && o_in_stall, "texel write outside idle")

endmodule

`default_nettype wire
